// File: hw/rtl/pcic_pkg.sv
`timescale 1ns / 1ps
`default_nettype none

package pcic_pkg;

    // Fixed sizes of the configuration
    localparam int BYTES_PER_SAMPLE = 8;
    localparam int ACC_WIDTH        = 32;

    // Word layout
    localparam int IN_BYTES = 8;
    localparam int PDM_W    = 8 * IN_BYTES;
    localparam int PCM_W    = 16;

    // One lane per byte that enters the integrators
    localparam int HALF_BYTES = BYTES_PER_SAMPLE / 2;
    localparam int LANES      = 2 * HALF_BYTES;

    // Closed-form coefficients of LANES integrator steps
    localparam int C_I1  = LANES;
    localparam int C_TRI = LANES * (LANES + 1) / 2;

    // Lane widths
    localparam int POP_W = 4;
    localparam int W1_W  = $clog2(LANES + 1);
    localparam int W2_W  = $clog2(C_TRI + 1);
    localparam int P1_W  = POP_W + W1_W;
    localparam int P2_W  = POP_W + W2_W;
    localparam int SUM_W = P2_W + $clog2(LANES + 1);

    // High-pass gain 63/64
    localparam int HPF_SHIFT = 6;
    localparam int HPF_BIAS  = 63;

    typedef logic [PDM_W-1:0]        t_pdm;
    typedef logic signed [PCM_W-1:0] t_pcm;
    typedef logic [ACC_WIDTH-1:0]    t_acc;
    typedef logic [POP_W-1:0]        t_pop;
    typedef logic [W1_W-1:0]         t_w1;
    typedef logic [W2_W-1:0]         t_w2;
    typedef logic [P1_W-1:0]         t_p1;
    typedef logic [P2_W-1:0]         t_p2;
    typedef logic [SUM_W-1:0]        t_sum;

    // Byte position taken by lane k: two halves, each from its top byte down
    function automatic int lane_byte(input int k);
        int g;
        int j;
        g = k / HALF_BYTES;
        j = k % HALF_BYTES;
        return g * HALF_BYTES + (HALF_BYTES - 1 - j);
    endfunction

    // Weight of lane k in the second integrator
    function automatic int lane_w1(input int k);
        return LANES - k;
    endfunction

    // Weight of lane k in the third integrator
    function automatic int lane_w2(input int k);
        return (LANES - k + 1) * (LANES - k) / 2;
    endfunction

endpackage

`default_nettype wire

// File: hw/rtl/pcic_if.sv
`timescale 1ns / 1ps
`default_nettype none

interface pcic_pdm_if;
    logic            valid;
    logic            ready;
    pcic_pkg::t_pdm  pdm_bytes;

    modport source (output valid, output pdm_bytes, input ready);
    modport sink   (input valid, input pdm_bytes, output ready);
endinterface

interface pcic_pcm_if;
    logic            valid;
    logic            ready;
    pcic_pkg::t_pcm  pcm_sample;

    modport source (output valid, output pcm_sample, input ready);
    modport sink   (input valid, input pcm_sample, output ready);
endinterface

`default_nettype wire

// File: hw/rtl/pcic_lane.sv
`timescale 1ns / 1ps
`default_nettype none

module pcic_lane import pcic_pkg::*; (
    input  wire logic       i_clk,
    input  wire logic       i_load,
    input  wire logic [7:0] i_byte,
    input  wire t_w1        i_w1,
    input  wire t_w2        i_w2,
    output t_pop            o_pop,
    output t_p1             o_p1,
    output t_p2             o_p2
);

    t_pop n_pop;
    t_pop r_pop;
    t_p1  r_p1;
    t_p2  r_p2;

    // Count one bits of the byte
    always_comb begin
        n_pop = '0;
        for (int b = 0; b < 8; b++) begin
            n_pop = n_pop + t_pop'(i_byte[b]);
        end
    end

    // Hold the count and its two weighted terms
    always_ff @(posedge i_clk) begin
        if (i_load) begin
            r_pop <= n_pop;
            r_p1  <= t_p1'(n_pop) * t_p1'(i_w1);
            r_p2  <= t_p2'(n_pop) * t_p2'(i_w2);
        end
    end

    assign o_pop = r_pop;
    assign o_p1  = r_p1;
    assign o_p2  = r_p2;

endmodule

`default_nettype wire

// File: hw/rtl/pcic_merge.sv
`timescale 1ns / 1ps
`default_nettype none

module pcic_merge import pcic_pkg::*; (
    input  wire logic i_clk,
    input  wire logic i_rst_n,
    input  wire logic i_valid,
    output logic      o_ready,
    input  wire t_pop i_pop [LANES],
    input  wire t_p1  i_p1  [LANES],
    input  wire t_p2  i_p2  [LANES],
    output logic      o_valid,
    input  wire logic i_ready,
    output t_sum      o_s0,
    output t_sum      o_s1,
    output t_sum      o_s2
);

    logic r_valid;
    t_sum n_s0, n_s1, n_s2;
    t_sum r_s0, r_s1, r_s2;
    logic load;

    assign o_ready = !r_valid || i_ready;
    assign load    = i_valid && o_ready;

    // Add up the lane terms
    always_comb begin
        n_s0 = '0;
        n_s1 = '0;
        n_s2 = '0;
        for (int k = 0; k < LANES; k++) begin
            n_s0 = n_s0 + t_sum'(i_pop[k]);
            n_s1 = n_s1 + t_sum'(i_p1[k]);
            n_s2 = n_s2 + t_sum'(i_p2[k]);
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (o_ready) begin
            r_valid <= i_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (load) begin
            r_s0 <= n_s0;
            r_s1 <= n_s1;
            r_s2 <= n_s2;
        end
    end

    assign o_valid = r_valid;
    assign o_s0    = r_s0;
    assign o_s1    = r_s1;
    assign o_s2    = r_s2;

endmodule

`default_nettype wire

// File: hw/rtl/pcic_cic.sv
`timescale 1ns / 1ps
`default_nettype none

module pcic_cic import pcic_pkg::*; (
    input  wire logic i_clk,
    input  wire logic i_rst_n,
    input  wire logic i_valid,
    output logic      o_ready,
    input  wire t_sum i_s0,
    input  wire t_sum i_s1,
    input  wire t_sum i_s2,
    output logic      o_valid,
    input  wire logic i_ready,
    output t_acc      o_diff
);

    // Integrator stage
    logic r_int_valid;
    logic int_ready;
    logic int_load;
    t_acc r_i1, r_i2, r_i3;
    t_acc n_i1, n_i2, n_i3;

    // Comb stage
    logic r_comb_valid;
    logic comb_ready;
    logic comb_load;
    t_acc r_dly [6];
    t_acc r_xprev;
    t_acc r_diff;
    t_acc c1, c2, c3;

    assign comb_ready = !r_comb_valid || i_ready;
    assign comb_load  = r_int_valid && comb_ready;
    assign int_ready  = !r_int_valid || comb_ready;
    assign int_load   = i_valid && int_ready;
    assign o_ready    = int_ready;

    // Advance all three integrators by a whole word of bytes
    always_comb begin
        n_i1 = r_i1 + t_acc'(i_s0);
        n_i2 = r_i2 + t_acc'(C_I1) * r_i1 + t_acc'(i_s1);
        n_i3 = r_i3 + t_acc'(C_I1) * r_i2 + t_acc'(C_TRI) * r_i1 + t_acc'(i_s2);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_int_valid <= 1'b0;
            r_i1        <= '0;
            r_i2        <= '0;
            r_i3        <= '0;
        end else begin
            if (int_ready) begin
                r_int_valid <= i_valid;
            end
            if (int_load) begin
                r_i1 <= n_i1;
                r_i2 <= n_i2;
                r_i3 <= n_i3;
            end
        end
    end

    // Three combs, each with a two-word delay
    assign c1 = r_i3 - r_dly[1];
    assign c2 = c1 - r_dly[3];
    assign c3 = c2 - r_dly[5];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_comb_valid <= 1'b0;
            for (int i = 0; i < 6; i++) begin
                r_dly[i] <= '0;
            end
            r_xprev <= '0;
        end else begin
            if (comb_ready) begin
                r_comb_valid <= r_int_valid;
            end
            if (comb_load) begin
                r_dly[0] <= r_i3;
                r_dly[1] <= r_dly[0];
                r_dly[2] <= c1;
                r_dly[3] <= r_dly[2];
                r_dly[4] <= c2;
                r_dly[5] <= r_dly[4];
                r_xprev  <= c3;
            end
        end
    end

    // Hand the high-pass its input step
    always_ff @(posedge i_clk) begin
        if (comb_load) begin
            r_diff <= c3 - r_xprev;
        end
    end

    assign o_valid = r_comb_valid;
    assign o_diff  = r_diff;

endmodule

`default_nettype wire

// File: hw/rtl/pcic_hpf.sv
`timescale 1ns / 1ps
`default_nettype none

module pcic_hpf import pcic_pkg::*; (
    input  wire logic i_clk,
    input  wire logic i_rst_n,
    input  wire logic i_valid,
    output logic      o_ready,
    input  wire t_acc i_diff,
    output logic      o_valid,
    input  wire logic i_ready,
    output t_pcm      o_pcm
);

    logic r_valid;
    logic load;
    t_acc r_y;
    t_acc sum;
    t_acc prod;
    t_acc biased;
    t_acc n_y;

    assign o_ready = !r_valid || i_ready;
    assign load    = i_valid && o_ready;

    // y = 63 * (y + x - xprev) / 64, truncating toward zero
    always_comb begin
        sum    = r_y + i_diff;
        prod   = (sum << HPF_SHIFT) - sum;
        biased = prod + (prod[ACC_WIDTH-1] ? t_acc'(HPF_BIAS) : '0);
        n_y    = t_acc'($signed(biased) >>> HPF_SHIFT);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
            r_y     <= '0;
        end else begin
            if (o_ready) begin
                r_valid <= i_valid;
            end
            if (load) begin
                r_y <= n_y;
            end
        end
    end

    assign o_valid = r_valid;
    assign o_pcm   = t_pcm'(r_y[PCM_W-1:0]);

endmodule

`default_nettype wire

// File: hw/rtl/pdm_cic3_decimator_dc_block.sv
// Path: a word accepted at the input is registered in turn by the lanes, the merge, the
// integrators, the combs and the high-pass output register before its sample is valid.
// Throughput: one word per cycle unless the output stalls; the integrator update and the
// high-pass feedback each close through one register; output stalls back up stage by stage.
// Reset: synchronous, active low; clears integrators, comb delays, high-pass state, valids.
`timescale 1ns / 1ps
`default_nettype none

module pdm_cic3_decimator_dc_block import pcic_pkg::*; (
    input  wire logic  i_clk,
    input  wire logic  i_rst_n,
    pcic_pdm_if.sink   i_pdm,
    pcic_pcm_if.source o_pcm
);

    logic r_lane_valid;
    logic lane_load;
    logic merge_ready;
    logic merge_valid;
    logic cic_ready;
    logic cic_valid;
    logic hpf_ready;

    t_pop lane_pop [LANES];
    t_p1  lane_p1  [LANES];
    t_p2  lane_p2  [LANES];
    t_sum s0, s1, s2;
    t_acc diff;

    assign i_pdm.ready = !r_lane_valid || merge_ready;
    assign lane_load   = i_pdm.valid && i_pdm.ready;

    // Lane stage valid
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_lane_valid <= 1'b0;
        end else if (i_pdm.ready) begin
            r_lane_valid <= i_pdm.valid;
        end
    end

    // One lane per integrator step, fed its byte in step order
    for (genvar k = 0; k < LANES; k++) begin : g_lane
        localparam int IDX = lane_byte(k);
        logic [7:0] lane_byte_val;

        if (IDX < IN_BYTES) begin : g_in
            assign lane_byte_val = i_pdm.pdm_bytes[8*IDX +: 8];
        end else begin : g_zero
            assign lane_byte_val = '0;
        end

        pcic_lane u_lane (
            .i_clk  (i_clk),
            .i_load (lane_load),
            .i_byte (lane_byte_val),
            .i_w1   (t_w1'(lane_w1(k))),
            .i_w2   (t_w2'(lane_w2(k))),
            .o_pop  (lane_pop[k]),
            .o_p1   (lane_p1[k]),
            .o_p2   (lane_p2[k])
        );
    end

    pcic_merge u_merge (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (r_lane_valid),
        .o_ready (merge_ready),
        .i_pop   (lane_pop),
        .i_p1    (lane_p1),
        .i_p2    (lane_p2),
        .o_valid (merge_valid),
        .i_ready (cic_ready),
        .o_s0    (s0),
        .o_s1    (s1),
        .o_s2    (s2)
    );

    pcic_cic u_cic (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (merge_valid),
        .o_ready (cic_ready),
        .i_s0    (s0),
        .i_s1    (s1),
        .i_s2    (s2),
        .o_valid (cic_valid),
        .i_ready (hpf_ready),
        .o_diff  (diff)
    );

    pcic_hpf u_hpf (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (cic_valid),
        .o_ready (hpf_ready),
        .i_diff  (diff),
        .o_valid (o_pcm.valid),
        .i_ready (o_pcm.ready),
        .o_pcm   (o_pcm.pcm_sample)
    );

endmodule

`default_nettype wire

// File: hw/rtl/pcic_checker.sv
`timescale 1ns / 1ps
`default_nettype none

module pcic_checker import pcic_pkg::*; (
    input wire logic i_clk,
    input wire logic i_rst_n,
    input wire logic i_in_ready,
    input wire logic i_out_valid,
    input wire logic i_out_ready,
    input wire t_pcm i_out_sample
);

    // Reset empties the pipeline
    a_reset_empty: assert property (@(posedge i_clk)
        !i_rst_n |=> !i_out_valid)
        else $error("output word valid after reset");

    // An empty output register means every stage can take a word
    a_empty_ready: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !i_out_valid |-> i_in_ready)
        else $error("input stalled while output is empty");

    // Hold a stalled word
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_out_valid && !i_out_ready |=> i_out_valid)
        else $error("output word dropped while stalled");

    a_out_stable: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_out_valid && !i_out_ready |=> $stable(i_out_sample))
        else $error("output word changed while stalled");

endmodule

bind pdm_cic3_decimator_dc_block pcic_checker u_pcic_checker (
    .i_clk        (i_clk),
    .i_rst_n      (i_rst_n),
    .i_in_ready   (i_pdm.ready),
    .i_out_valid  (o_pcm.valid),
    .i_out_ready  (o_pcm.ready),
    .i_out_sample (o_pcm.pcm_sample)
);

`default_nettype wire

// File: verif/tb_pdm_cic3_decimator_dc_block.sv
`timescale 1ns / 1ps

module tb_pdm_cic3_decimator_dc_block;
    import pcic_pkg::*;

    localparam int DIR_ROWS    = 20;
    localparam int RAND_WORDS  = 1350;
    localparam int HOLD_CYCLES = 400;
    localparam int DRAIN_WAIT  = 16;

    typedef enum int {
        SEG_NOISE,
        SEG_DENSITY,
        SEG_HIGH,
        SEG_LOW
    } t_seg_kind;

    logic i_clk = 1'b0;
    logic i_rst_n = 1'b0;

    pcic_pdm_if pdm_if ();
    pcic_pcm_if pcm_if ();

    pdm_cic3_decimator_dc_block dut (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_pdm   (pdm_if),
        .o_pcm   (pcm_if)
    );

    always #1 i_clk = ~i_clk;

    // Directed words; only the first two samples are typed in by hand
    t_pdm dir_word [DIR_ROWS] = '{
        64'h0000_0000_0000_0000, 64'hFFFF_FFFF_FFFF_FFFF,
        64'hFFFF_FFFF_FFFF_FFFF, 64'hFFFF_FFFF_FFFF_FFFF,
        64'hFFFF_FFFF_FFFF_FFFF, 64'h0000_0000_0000_0000,
        64'h0000_0000_0000_0000, 64'h0000_0000_0000_0000,
        64'h5555_5555_5555_5555, 64'hAAAA_AAAA_AAAA_AAAA,
        64'h0000_0000_FF00_0000, 64'h0000_00FF_0000_0000,
        64'h0000_0000_0000_00FF, 64'hFF00_0000_0000_0000,
        64'h8000_0000_0000_0001, 64'h0123_4567_89AB_CDEF,
        64'hFEDC_BA98_7654_3210, 64'h0F0F_0F0F_F0F0_F0F0,
        64'h0000_0001_0000_0000, 64'h7FFF_FFFF_FFFF_FFFE
    };
    bit   dir_known [DIR_ROWS] = '{1, 1, 0, 0, 0, 0, 0, 0, 0, 0,
                                   0, 0, 0, 0, 0, 0, 0, 0, 0, 0};
    t_pcm dir_pcm   [DIR_ROWS] = '{16'sd0, 16'sd945, 16'sd0, 16'sd0, 16'sd0,
                                   16'sd0, 16'sd0, 16'sd0, 16'sd0, 16'sd0,
                                   16'sd0, 16'sd0, 16'sd0, 16'sd0, 16'sd0,
                                   16'sd0, 16'sd0, 16'sd0, 16'sd0, 16'sd0};

    // Filter state of the predictor
    t_acc integ_1 = '0;
    t_acc integ_2 = '0;
    t_acc integ_3 = '0;
    t_acc comb_dly [6] = '{default: '0};
    t_acc hpf_x = '0;
    t_acc hpf_y = '0;

    t_pcm pcm_due_q [$];
    int   fail_count = 0;

    // Word on the input channel: whether its sample is typed in, and which
    bit   word_known = 1'b0;
    t_pcm word_pcm = '0;

    bit tx_steady = 1'b0;
    bit rx_steady = 1'b0;
    bit hold_req  = 1'b0;

    // Advance the CIC and the high-pass by one word, return the sample
    function automatic t_pcm cic_hpf_step(input t_pdm w);
        t_acc x;
        t_acc d;
        t_acc s;
        t_acc y;
        int   idx;
        for (int g = 0; g < 2; g++) begin
            for (int j = 0; j < HALF_BYTES; j++) begin
                idx = g * HALF_BYTES + (HALF_BYTES - 1 - j);
                integ_1 = integ_1 + t_acc'($countones(w[8*idx +: 8]));
                integ_2 = integ_2 + integ_1;
                integ_3 = integ_3 + integ_2;
            end
        end
        x = integ_3;
        for (int c = 0; c < 3; c++) begin
            d = x - comb_dly[2*c+1];
            comb_dly[2*c+1] = comb_dly[2*c];
            comb_dly[2*c] = x;
            x = d;
        end
        s = hpf_y + x - hpf_x;
        s = s * 32'd63;
        y = t_acc'($signed(s) / 32'sd64);
        hpf_x = x;
        hpf_y = y;
        return t_pcm'(y[PCM_W-1:0]);
    endfunction

    // Idle length: mostly none or short, a few long
    function automatic int idle_len(input bit steady);
        int r;
        r = $urandom_range(0, 99);
        if (steady || r < 60)
            return 0;
        if (r < 90)
            return $urandom_range(1, 3);
        return $urandom_range(8, 40);
    endfunction

    // Offer one word from a falling edge and hold it until taken
    task automatic send_word(input t_pdm w, input bit known, input t_pcm pcm);
        int gap;
        gap = idle_len(tx_steady);
        if (gap > 0) begin
            pdm_if.valid <= 1'b0;
            repeat (gap) @(negedge i_clk);
        end
        pdm_if.valid     <= 1'b1;
        pdm_if.pdm_bytes <= w;
        word_known       <= known;
        word_pcm         <= pcm;
        do @(posedge i_clk); while (!pdm_if.ready);
        @(negedge i_clk);
    endtask

    // Predict on each accepted word, check each accepted sample
    always @(posedge i_clk) begin
        if (i_rst_n) begin
            if (pcm_if.valid && pcm_if.ready) begin
                if (pcm_due_q.size() == 0) begin
                    fail_count++;
                    $display("%0t: pcm_sample %0d with no sample pending",
                             $time, pcm_if.pcm_sample);
                end else if (pcm_if.pcm_sample !== pcm_due_q[0]) begin
                    fail_count++;
                    $display("%0t: pcm_sample mismatch: expected %0d, got %0d",
                             $time, pcm_due_q[0], pcm_if.pcm_sample);
                    void'(pcm_due_q.pop_front());
                end else begin
                    void'(pcm_due_q.pop_front());
                end
            end
            if (pdm_if.valid && pdm_if.ready) begin
                if (word_known) begin
                    void'(cic_hpf_step(pdm_if.pdm_bytes));
                    pcm_due_q.push_back(word_pcm);
                end else begin
                    pcm_due_q.push_back(cic_hpf_step(pdm_if.pdm_bytes));
                end
            end
        end
    end

    // Drive the output ready with random stalls and one long hold-off
    initial begin
        int idle_left;
        idle_left = 0;
        pcm_if.ready <= 1'b0;
        forever begin
            @(negedge i_clk);
            if (hold_req) begin
                hold_req = 1'b0;
                idle_left = HOLD_CYCLES;
            end
            if (idle_left > 0) begin
                pcm_if.ready <= 1'b0;
                idle_left--;
            end else begin
                pcm_if.ready <= 1'b1;
                if ($urandom_range(0, 3) == 0)
                    idle_left = idle_len(rx_steady);
            end
        end
    end

    // Abort a hung run
    initial begin
        #2000000;
        $display("Test completed with failures");
        $finish;
    end

    // Stimulus
    initial begin
        t_seg_kind kind;
        t_pdm      w;
        int        sent;
        int        seg_len;
        int        dens;
        bit        hold_done;

        sent = 0;
        hold_done = 1'b0;
        pdm_if.valid     <= 1'b0;
        pdm_if.pdm_bytes <= '0;

        repeat (7) @(negedge i_clk);
        i_rst_n <= 1'b1;
        @(negedge i_clk);

        // Directed part
        for (int i = 0; i < DIR_ROWS; i++)
            send_word(dir_word[i], dir_known[i], dir_pcm[i]);

        // Random part: segments of steady density, noise and saturated input
        while (sent < RAND_WORDS) begin
            kind = t_seg_kind'($urandom_range(0, 3));
            seg_len = $urandom_range(8, 48);
            dens = $urandom_range(0, 16);
            tx_steady = ($urandom_range(0, 4) == 0);
            rx_steady = ($urandom_range(0, 4) == 0);
            if (!hold_done && sent > 500) begin
                hold_done = 1'b1;
                tx_steady = 1'b1;
                hold_req = 1'b1;
            end
            for (int i = 0; i < seg_len; i++) begin
                case (kind)
                    SEG_NOISE: begin
                        w = {$urandom, $urandom};
                    end
                    SEG_DENSITY: begin
                        for (int b = 0; b < PDM_W; b++)
                            w[b] = ($urandom_range(0, 15) < dens);
                    end
                    SEG_HIGH: begin
                        w = '1;
                        if ($urandom_range(0, 3) == 0)
                            w[$urandom_range(0, PDM_W-1)] = 1'b0;
                    end
                    default: begin
                        w = '0;
                        if ($urandom_range(0, 3) == 0)
                            w[$urandom_range(0, PDM_W-1)] = 1'b1;
                    end
                endcase
                send_word(w, 1'b0, '0);
                sent++;
            end
        end
        pdm_if.valid <= 1'b0;
        tx_steady = 1'b0;
        rx_steady = 1'b0;

        // Drain, then let the pipeline settle
        while (pcm_due_q.size() != 0)
            @(posedge i_clk);
        repeat (DRAIN_WAIT) @(posedge i_clk);

        if (fail_count == 0) begin
            $display("Test completed successfully");
        end else begin
            $display("Test completed with failures");
        end
        $finish;
    end

endmodule

// File: pdm_cic3_decimator_dc_block.f
hw/rtl/pcic_pkg.sv
hw/rtl/pcic_if.sv
hw/rtl/pcic_lane.sv
hw/rtl/pcic_merge.sv
hw/rtl/pcic_cic.sv
hw/rtl/pcic_hpf.sv
hw/rtl/pdm_cic3_decimator_dc_block.sv
hw/rtl/pcic_checker.sv
verif/tb_pdm_cic3_decimator_dc_block.sv
